[hw/rtl/assert_macros.svh]
// assertion helpers shared by the downscaler rtl
// define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// condition that must hold in the cycle after a trigger
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk_s, rstn_s, prop, msg)
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

[hw/rtl/nnd_pkg.sv]
// ----------------------------------------------------------------------------
// nnd_pkg
// Types and constants shared by the nearest neighbor downscaler modules.
// ----------------------------------------------------------------------------
package nnd_pkg;

  localparam int SIZE_W         = 13;
  localparam int STEP_W         = 29;
  localparam int COORD_W        = 12;
  localparam int ACC_W          = 32;
  localparam int FRAC_W         = 16;
  localparam int PIX_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 29;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RESET_STEP     = 65537;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3,
    REG_COLUMN_STEP   = 3'd4,
    REG_ROW_STEP      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] source_width;
    logic [SIZE_W-1:0] source_height;
    logic [SIZE_W-1:0] target_width;
    logic [SIZE_W-1:0] target_height;
    logic [STEP_W-1:0] column_step;
    logic [STEP_W-1:0] row_step;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_byte_zero;
    logic [PIX_W-1:0] pixel_byte_one;
    logic [PIX_W-1:0] pixel_byte_two;
  } in_payload_t;

  typedef struct packed {
    logic [PIX_W-1:0]   out_byte_zero;
    logic [PIX_W-1:0]   out_byte_one;
    logic [PIX_W-1:0]   out_byte_two;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic               frame_last;
  } out_payload_t;

  // selection status from the scan counters to the output stage
  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last;
  } hit_t;

endpackage

[hw/rtl/nnd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// nnd_cfg_regs
// Configuration register file: sizes and 13.16 steps, written by index.
// ----------------------------------------------------------------------------
module nnd_cfg_regs import nnd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  cfg_nxt.source_width  = cfg_wdata[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: cfg_nxt.source_height = cfg_wdata[SIZE_W-1:0];
        REG_TARGET_WIDTH:  cfg_nxt.target_width  = cfg_wdata[SIZE_W-1:0];
        REG_TARGET_HEIGHT: cfg_nxt.target_height = cfg_wdata[SIZE_W-1:0];
        REG_COLUMN_STEP:   cfg_nxt.column_step   = cfg_wdata[STEP_W-1:0];
        REG_ROW_STEP:      cfg_nxt.row_step      = cfg_wdata[STEP_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= SIZE_W'(1);
      cfg_r.source_height <= SIZE_W'(1);
      cfg_r.target_width  <= SIZE_W'(1);
      cfg_r.target_height <= SIZE_W'(1);
      cfg_r.column_step   <= STEP_W'(RESET_STEP);
      cfg_r.row_step      <= STEP_W'(RESET_STEP);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/nnd_scan.sv]
// ----------------------------------------------------------------------------
// nnd_scan
// Source position counters and 16.16 accumulators that pick the source
// pixels kept for the output image.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nnd_scan import nnd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic fire,
  output hit_t hit
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WCW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int WRW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  logic [CW-1:0]     src_col_r, src_col_nxt;
  logic [RW-1:0]     src_row_r, src_row_nxt;
  logic [SIZE_W-1:0] out_col_r, out_col_nxt;
  logic [SIZE_W-1:0] out_row_r, out_row_nxt;
  logic [ACC_W-1:0]  col_acc_r, col_acc_nxt;
  logic [ACC_W-1:0]  row_acc_r, row_acc_nxt;
  logic              row_chosen_r, row_chosen_nxt;

  logic [WCW-1:0] eff_w;
  logic [WRW-1:0] eff_h;
  logic [CW:0]    col_inc;
  logic [RW:0]    row_inc;
  logic           col_wrap;
  logic           row_wrap;
  logic           row_adv;
  logic           emit;

  // effective source size: zero reads as one, clamp to the maximum
  always_comb begin
    if (cfg.source_width == '0) begin
      eff_w = WCW'(1);
    end else if (WCW'(cfg.source_width) > WCW'(MAX_WIDTH)) begin
      eff_w = WCW'(MAX_WIDTH);
    end else begin
      eff_w = WCW'(cfg.source_width);
    end
    if (cfg.source_height == '0) begin
      eff_h = WRW'(1);
    end else if (WRW'(cfg.source_height) > WRW'(MAX_HEIGHT)) begin
      eff_h = WRW'(MAX_HEIGHT);
    end else begin
      eff_h = WRW'(cfg.source_height);
    end
  end

  // selection of the current source pixel
  assign emit = row_chosen_r && (out_row_r < cfg.target_height) &&
                (out_col_r < cfg.target_width) &&
                (col_acc_r[ACC_W-1:FRAC_W] == FRAC_W'(src_col_r));

  assign col_inc  = {1'b0, src_col_r} + 1'b1;
  assign row_inc  = {1'b0, src_row_r} + 1'b1;
  assign col_wrap = WCW'(col_inc) >= eff_w;
  assign row_wrap = WRW'(row_inc) >= eff_h;
  assign row_adv  = row_chosen_r && (out_row_r < cfg.target_height);

  // counter update per transfer
  always_comb begin
    src_col_nxt    = src_col_r;
    src_row_nxt    = src_row_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    col_acc_nxt    = col_acc_r;
    row_acc_nxt    = row_acc_r;
    row_chosen_nxt = row_chosen_r;
    if (fire) begin
      if (emit) begin
        out_col_nxt = out_col_r + 1'b1;
        col_acc_nxt = col_acc_r + ACC_W'(cfg.column_step);
      end
      if (!col_wrap) begin
        src_col_nxt = col_inc[CW-1:0];
      end else begin
        // end of source row
        src_col_nxt = '0;
        out_col_nxt = '0;
        col_acc_nxt = '0;
        if (row_wrap) begin
          src_row_nxt = '0;
          out_row_nxt = '0;
          row_acc_nxt = '0;
        end else begin
          src_row_nxt = row_inc[RW-1:0];
          if (row_adv) begin
            out_row_nxt = out_row_r + 1'b1;
            row_acc_nxt = row_acc_r + ACC_W'(cfg.row_step);
          end
        end
        row_chosen_nxt = row_acc_nxt[ACC_W-1:FRAC_W] == FRAC_W'(src_row_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r    <= '0;
      src_row_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      col_acc_r    <= '0;
      row_acc_r    <= '0;
      row_chosen_r <= 1'b1;
    end else begin
      src_col_r    <= src_col_nxt;
      src_row_r    <= src_row_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
      col_acc_r    <= col_acc_nxt;
      row_acc_r    <= row_acc_nxt;
      row_chosen_r <= row_chosen_nxt;
    end
  end

  // status toward the output stage
  assign hit.emit   = emit;
  assign hit.column = out_col_r[COORD_W-1:0];
  assign hit.row    = out_row_r[COORD_W-1:0];
  assign hit.last   = (out_row_r == cfg.target_height - 1'b1) &&
                      (out_col_r == cfg.target_width - 1'b1);

  `ASSERT_NEXT(a_row_end_clears, clk, rst_n, fire && col_wrap, (src_col_r == '0) && (out_col_r == '0) && (col_acc_r == '0), "row end did not clear column state")
  `ASSERT_NEXT(a_col_advance, clk, rst_n, fire && emit && !col_wrap, out_col_r == $past(out_col_r) + 1'b1, "output column did not advance")

endmodule

[hw/rtl/nnd_out_stage.sv]
// ----------------------------------------------------------------------------
// nnd_out_stage
// Result register: swaps the outer color bytes, attaches coordinates and
// holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nnd_out_stage import nnd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  hit_t         hit,
  input  logic         in_valid,
  input  in_payload_t  in_data,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output out_payload_t out_data
);

  logic         out_valid_r, out_valid_nxt;
  out_payload_t out_data_r, out_data_nxt;
  logic         load;

  // an unselected pixel never needs the result register
  assign in_ready = !hit.emit || !out_valid_r || out_ready;
  assign load     = in_valid && in_ready && hit.emit;

  always_comb begin
    out_valid_nxt = (out_valid_r && !out_ready) || load;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_data_nxt.out_byte_zero = in_data.pixel_byte_two;
      out_data_nxt.out_byte_one  = in_data.pixel_byte_one;
      out_data_nxt.out_byte_two  = in_data.pixel_byte_zero;
      out_data_nxt.out_column    = hit.column;
      out_data_nxt.out_row       = hit.row;
      out_data_nxt.frame_last    = hit.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_valid_r && (out_data_r.out_column == $past(hit.column)) && (out_data_r.out_row == $past(hit.row)), "loaded result not presented")
  `ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !(out_valid_r && !out_ready && load), "pending result overwritten")

endmodule

[hw/rtl/nearest_neighbor_downscaler.sv]
// output: a selected pixel shows on out_valid in the cycle after its transfer
// throughput: one source pixel per cycle; a pixel is held off only when it
//   is selected while the result register is full and out_ready is low
// reset (synchronous, rst_n low): counters and accumulators cleared, row zero
//   selected, sizes set to one and steps to 65537, result register empty
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// Streaming nearest neighbor downscaler with 13.16 fixed point steps.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler import nnd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_payload_t           in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_payload_t          out_data
);

  cfg_t cfg;
  hit_t hit;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  // configuration registers
  nnd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // source scan and pixel selection
  nnd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (in_fire),
    .hit   (hit)
  );

  // result register
  nnd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit       (hit),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
